[src/hdt_pkg.sv]
// Package for the header dynamic table: field widths, request and status codes,
// and the command record passed from the front to the back part and the back part's result record.
// No dependencies.
`default_nettype none

package hdt_pkg;

  localparam int REQ_W      = 2;
  localparam int LEN_W      = 15;
  localparam int TIDX_W     = 16;
  localparam int NMAX_W     = 16;
  localparam int CFG_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;
  localparam int EVCT_OUT_W = 8;
  // Two lengths plus the overhead fit in 17 bits.
  localparam int COST_W     = 17;

  localparam int ENTRY_OVERHEAD  = 32;
  localparam int STATIC_ENTRIES  = 61;
  localparam int INIT_MAX_BYTES  = 4096;
  localparam int DEF_MAX_BYTES   = 4096;
  localparam int DEF_MAX_ENTRIES = 128;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 2'd3;

  // Classified request as it leaves the front part.
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [LEN_W-1:0]  nlen;
    logic [LEN_W-1:0]  vlen;
    logic [COST_W-1:0] cost;
    logic [TIDX_W-1:0] back_ofs;   // distance back from the newest entry
    logic [NMAX_W-1:0] new_max;
    logic              idx_low;    // index names a static entry or less
    logic              max_over;   // requested budget above the limit
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [LEN_W-1:0]      nlen;
    logic [LEN_W-1:0]      vlen;
    logic [SLOT_OUT_W-1:0] slot;
    logic [EVCT_OUT_W-1:0] evicted;
  } res_t;

endpackage

`default_nettype wire

[src/hdt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module hdt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

[src/hdt_fifo.sv]
// Small show-ahead queue of fixed-width items.
// No dependencies.
`default_nettype none

module hdt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/hdt_front.sv]
// Front part: accepts requests, precomputes the state-independent checks and
// queues the classified command. Depends on hdt_pkg and hdt_fifo.
`default_nettype none

module hdt_front
  import hdt_pkg::*;
#(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [LEN_W-1:0]  in_name_length,
  input  wire logic [LEN_W-1:0]  in_value_length,
  input  wire logic [TIDX_W-1:0] in_table_index,
  input  wire logic [NMAX_W-1:0] in_new_max_bytes,
  input  wire logic              cmd_pop,
  output cmd_t                   cmd_head,
  output logic                   cmd_empty
);

  localparam int CMD_W = $bits(cmd_t);

  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_in_vec, cmd_head_vec;

  always_comb begin
    cmd_in.req       = in_req_type;
    cmd_in.nlen      = in_name_length;
    cmd_in.vlen      = in_value_length;
    cmd_in.cost      = COST_W'(in_name_length) + COST_W'(in_value_length)
                     + COST_W'(ENTRY_OVERHEAD);
    cmd_in.back_ofs  = in_table_index - TIDX_W'(STATIC_ENTRIES + 1);
    cmd_in.new_max   = in_new_max_bytes;
    cmd_in.idx_low   = (in_table_index <= TIDX_W'(STATIC_ENTRIES));
    cmd_in.max_over  = ({16'd0, in_new_max_bytes} > 32'(MAX_BYTES));
  end

  assign cmd_in_vec = cmd_in;
  assign cmd_head   = cmd_t'(cmd_head_vec);

  hdt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd_in_vec),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head_vec),
    .empty     (cmd_empty)
  );

endmodule

`default_nettype wire

[src/hdt_back.sv]
// Back part: table state, entry RAM and the sequencer that carries out add,
// lookup, resize and budget writes. Depends on hdt_pkg and hdt_ram.
`default_nettype none

module hdt_back
  import hdt_pkg::*;
#(
  parameter int MAX_BYTES   = DEF_MAX_BYTES,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire cmd_t             cmd_head,
  input  wire logic             cmd_empty,
  output logic                  cmd_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output res_t                  res_data
);

  localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);
  localparam int SUM_W   = COST_W + 1;
  localparam int RING_W  = CNT_W + 1;
  localparam int ENT_W   = 2 * LEN_W;
  localparam int RESET_MAX = (INIT_MAX_BYTES > MAX_BYTES) ? MAX_BYTES : INIT_MAX_BYTES;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EVICT   = 2'd1;
  localparam logic [1:0] S_EV_UPD  = 2'd2;
  localparam logic [1:0] S_LK_WAIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [SLOT_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [BYTES_W-1:0] cur_max_r, cur_max_nxt;
  logic [CNT_W-1:0]   evicted_r, evicted_nxt;
  logic               silent_r, silent_nxt;
  logic [REQ_W-1:0]   op_req_r, op_req_nxt;
  logic [COST_W-1:0]  op_cost_r, op_cost_nxt;
  logic [ENT_W-1:0]   op_lens_r, op_lens_nxt;
  logic [SLOT_W-1:0]  lk_slot_r, lk_slot_nxt;

  logic               cfg_fire;
  logic               lk_in_range;
  logic [CNT_W-1:0]   lk_offset;
  logic [RING_W-1:0]  lk_sum, wr_sum;
  logic [SLOT_W-1:0]  lk_slot, wr_slot, oldest_inc;
  logic [COST_W-1:0]  extra;
  logic [SUM_W-1:0]   need_sum;
  logic               need_evict, ring_full;
  logic [COST_W-1:0]  ev_cost;
  logic [BYTES_W-1:0] bytes_base;
  logic [CNT_W-1:0]   evicted_out_src;
  logic [EVCT_OUT_W-1:0] evicted_out;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_rd_addr;
  logic [ENT_W-1:0]   ram_rd_data;

  assign cfg_ready = (state_r == S_IDLE) && cmd_empty;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Lookup: entry back_ofs steps before the newest sits at oldest + offset.
  assign lk_in_range = (COST_W'(cmd_head.back_ofs) < COST_W'(count_r));
  assign lk_offset   = CNT_W'(COST_W'(count_r) - COST_W'(cmd_head.back_ofs) - 1'b1);
  assign lk_sum      = RING_W'(oldest_r) + RING_W'(lk_offset);
  assign lk_slot     = (lk_sum >= RING_W'(MAX_ENTRIES)) ?
                       SLOT_W'(lk_sum - RING_W'(MAX_ENTRIES)) : SLOT_W'(lk_sum);

  assign wr_sum  = RING_W'(oldest_r) + RING_W'(count_r);
  assign wr_slot = (wr_sum >= RING_W'(MAX_ENTRIES)) ?
                   SLOT_W'(wr_sum - RING_W'(MAX_ENTRIES)) : SLOT_W'(wr_sum);
  assign oldest_inc = (oldest_r == SLOT_W'(MAX_ENTRIES - 1)) ? '0 : oldest_r + 1'b1;

  assign extra      = (op_req_r == REQ_ADD) ? op_cost_r : '0;
  assign need_sum   = SUM_W'(bytes_r) + SUM_W'(extra);
  assign need_evict = (count_r != '0) && (need_sum > SUM_W'(cur_max_r));
  assign ring_full  = (count_r == CNT_W'(MAX_ENTRIES));

  assign ev_cost = COST_W'(ram_rd_data[LEN_W-1:0]) + COST_W'(ram_rd_data[ENT_W-1:LEN_W])
                 + COST_W'(ENTRY_OVERHEAD);
  assign bytes_base = (count_r == '0) ? '0 : bytes_r;

  assign evicted_out_src = evicted_r;
  assign evicted_out = (32'(evicted_out_src) > 32'd255) ? 8'd255 : EVCT_OUT_W'(evicted_out_src);

  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    cur_max_nxt = cur_max_r;
    evicted_nxt = evicted_r;
    silent_nxt  = silent_r;
    op_req_nxt  = op_req_r;
    op_cost_nxt = op_cost_r;
    op_lens_nxt = op_lens_r;
    lk_slot_nxt = lk_slot_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_data    = '0;
    ram_we      = 1'b0;
    ram_rd_addr = oldest_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          cur_max_nxt = (32'(cfg_data) > 32'(MAX_BYTES)) ?
                        BYTES_W'(MAX_BYTES) : BYTES_W'(cfg_data);
          op_req_nxt  = REQ_RESIZE;
          silent_nxt  = 1'b1;
          evicted_nxt = '0;
          state_nxt   = S_EVICT;
        end else if (!cmd_empty && !res_full) begin
          cmd_pop     = 1'b1;
          op_req_nxt  = cmd_head.req;
          op_cost_nxt = cmd_head.cost;
          op_lens_nxt = {cmd_head.vlen, cmd_head.nlen};
          silent_nxt  = 1'b0;
          evicted_nxt = '0;
          case (cmd_head.req)
            REQ_ADD: begin
              if (cmd_head.cost > COST_W'(cur_max_r)) begin
                res_push        = 1'b1;
                res_data.status = ST_TOO_LONG;
              end else begin
                state_nxt = S_EVICT;
              end
            end
            REQ_LOOKUP: begin
              if (cmd_head.idx_low || !lk_in_range) begin
                res_push        = 1'b1;
                res_data.status = ST_NOT_FOUND;
              end else begin
                ram_rd_addr = lk_slot;
                lk_slot_nxt = lk_slot;
                state_nxt   = S_LK_WAIT;
              end
            end
            REQ_RESIZE: begin
              if (cmd_head.max_over) begin
                res_push        = 1'b1;
                res_data.status = ST_OVER_LIMIT;
              end else begin
                cur_max_nxt = BYTES_W'(cmd_head.new_max);
                state_nxt   = S_EVICT;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_EVICT: begin
        if (need_evict || ((op_req_r == REQ_ADD) && ring_full)) begin
          ram_rd_addr = oldest_r;
          state_nxt   = S_EV_UPD;
        end else if (op_req_r == REQ_ADD) begin
          ram_we           = 1'b1;
          count_nxt        = count_r + 1'b1;
          bytes_nxt        = bytes_base + BYTES_W'(op_cost_r);
          res_push         = 1'b1;
          res_data.status  = ST_OK;
          res_data.slot    = SLOT_OUT_W'(wr_slot);
          res_data.evicted = evicted_out;
          state_nxt        = S_IDLE;
        end else begin
          bytes_nxt = bytes_base;
          if (!silent_r) begin
            res_push         = 1'b1;
            res_data.status  = ST_OK;
            res_data.evicted = evicted_out;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EV_UPD: begin
        bytes_nxt   = (ev_cost > COST_W'(bytes_r)) ? '0 : bytes_r - BYTES_W'(ev_cost);
        oldest_nxt  = oldest_inc;
        count_nxt   = count_r - 1'b1;
        evicted_nxt = evicted_r + 1'b1;
        state_nxt   = S_EVICT;
      end
      S_LK_WAIT: begin
        res_push          = 1'b1;
        res_data.status   = ST_OK;
        res_data.nlen     = ram_rd_data[LEN_W-1:0];
        res_data.vlen     = ram_rd_data[ENT_W-1:LEN_W];
        res_data.slot     = SLOT_OUT_W'(lk_slot_r);
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oldest_r  <= '0;
      count_r   <= '0;
      bytes_r   <= '0;
      cur_max_r <= BYTES_W'(RESET_MAX);
      evicted_r <= '0;
      silent_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      count_r   <= count_nxt;
      bytes_r   <= bytes_nxt;
      cur_max_r <= cur_max_nxt;
      evicted_r <= evicted_nxt;
      silent_r  <= silent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_req_r  <= op_req_nxt;
    op_cost_r <= op_cost_nxt;
    op_lens_r <= op_lens_nxt;
    lk_slot_r <= lk_slot_nxt;
  end

  hdt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (wr_slot),
    .wr_data   (op_lens_r),
    .rd_addr   (ram_rd_addr),
    .rd_data_r (ram_rd_data)
  );

endmodule

`default_nettype wire

[src/header_dynamic_table.sv]
// Top level of the header dynamic table bookkeeping engine.
// Depends on hdt_pkg, hdt_front, hdt_back and hdt_fifo.
//
// This block keeps the entry list of a header-compression dynamic table: a
// ring of up to MAX_ENTRIES entries, each a name length and a value length,
// costing both lengths plus 32 bytes against a byte budget. Requests are
// pushed like into a queue (push, full) and each gives exactly one result,
// read like from a queue (empty, pop). An add evicts oldest entries until the
// new one fits and reports the ring slot it took; an external string store
// keyed by that slot holds the bytes. A lookup by combined index (62 is the
// newest entry) returns the lengths and slot. A resize loads a new budget and
// evicts to fit. The budget register on the cfg channel acts as a resize that
// gives no result; it is accepted only when the block is idle. A request
// is handled in the idle state alone when it is rejected at once; a lookup
// also passes the lookup wait state, an add or resize the eviction check,
// and every evicted entry adds one read of the oldest entry from the
// single-read-port entry RAM and one update of the running byte count. A
// two-deep command queue and a two-deep result queue keep the input and
// output sides running while the sequencer works. The entry RAM is not
// cleared after reset; only entries that were written are ever read.
`default_nettype none

module header_dynamic_table
  import hdt_pkg::*;
#(
  parameter int MAX_BYTES   = DEF_MAX_BYTES,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request side
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [LEN_W-1:0]      in_name_length,
  input  wire logic [LEN_W-1:0]      in_value_length,
  input  wire logic [TIDX_W-1:0]     in_table_index,
  input  wire logic [NMAX_W-1:0]     in_new_max_bytes,
  // Result side
  output logic                       empty,
  input  wire logic                  pop,
  output logic [STATUS_W-1:0]        out_status,
  output logic [LEN_W-1:0]           out_found_name_length,
  output logic [LEN_W-1:0]           out_found_value_length,
  output logic [SLOT_OUT_W-1:0]      out_entry_slot,
  output logic [EVCT_OUT_W-1:0]      out_evicted_count,
  // Budget register write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_initial_max_bytes
);

  localparam int RES_W = $bits(res_t);

  cmd_t             cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  res_t             res_data;
  res_t             res_head;
  logic [RES_W-1:0] res_data_vec, res_head_vec;

  // Front: classification and the command queue.
  hdt_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_name_length   (in_name_length),
    .in_value_length  (in_value_length),
    .in_table_index   (in_table_index),
    .in_new_max_bytes (in_new_max_bytes),
    .cmd_pop          (cmd_pop),
    .cmd_head         (cmd_head),
    .cmd_empty        (cmd_empty)
  );

  // Back: table state, entry RAM and the eviction sequencer.
  hdt_back #(
    .MAX_BYTES   (MAX_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_initial_max_bytes),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // The result queue decouples finished items from the consumer.
  assign res_data_vec = res_data;
  assign res_head     = res_t'(res_head_vec);

  hdt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data_vec),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head_vec),
    .empty     (empty)
  );

  assign out_status             = res_head.status;
  assign out_found_name_length  = res_head.nlen;
  assign out_found_value_length = res_head.vlen;
  assign out_entry_slot         = res_head.slot;
  assign out_evicted_count      = res_head.evicted;

endmodule

`default_nettype wire
